// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the 4x4 column transform checker. All macros
// sample on posedge clk, which must be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define MCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included
`define MCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and constants for the 4x4 column transform unit.
// ----------------------------------------------------------------------------
package mct_pkg;

    // Defaults for the top level parameters
    localparam int DIM_DEF       = 4;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed word geometry: four vector elements in, four rows out
    localparam int VEC_LEN = 4;
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 2 * DATA_W;
    // Sum of four full products needs two guard bits
    localparam int ACC_W   = PROD_W + 2;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Command codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [1:0]               column_index;
        logic signed [DATA_W-1:0] vec_in0;
        logic signed [DATA_W-1:0] vec_in1;
        logic signed [DATA_W-1:0] vec_in2;
        logic signed [DATA_W-1:0] vec_in3;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res0;
        logic signed [DATA_W-1:0] res1;
        logic signed [DATA_W-1:0] res2;
        logic signed [DATA_W-1:0] res3;
        logic                     saturated;
    } out_word_t;

    // Stage enables from the top level to every lane
    typedef struct packed {
        logic adv_mul;
        logic adv_add;
    } lane_ctrl_t;

endpackage

// ===== rtl/mct_lane.sv =====
// ----------------------------------------------------------------------------
// mct_lane
// One row dot product: registered multipliers, registered pair adds, then
// the final add, floor shift by the fraction bits and 32-bit saturation.
// ----------------------------------------------------------------------------
module mct_lane #(
    parameter int N         = mct_pkg::VEC_LEN,
    parameter int FRAC_BITS = mct_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  mct_pkg::lane_ctrl_t              ctrl,
    input  logic signed [mct_pkg::DATA_W-1:0] row_elem [N],
    input  logic signed [mct_pkg::DATA_W-1:0] vec_elem [N],
    output logic signed [mct_pkg::DATA_W-1:0] res,
    output logic                             sat
);
    import mct_pkg::*;

    localparam int P = (N + 1) / 2;

    logic signed [PROD_W-1:0] prod_reg  [N];
    logic signed [PROD_W-1:0] prod_next [N];
    logic signed [ACC_W-1:0]  pair_reg  [P];
    logic signed [ACC_W-1:0]  pair_next [P];
    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-DATA_W:0]    upper;

    // Stage 1: one 32x32 signed product per column
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            prod_next[i] = PROD_W'(row_elem[i]) * PROD_W'(vec_elem[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_mul)
        begin
            prod_reg <= prod_next;
        end
    end

    // Stage 2: add products in pairs
    for (genvar p = 0; p < P; p++)
    begin : g_pair
        if (2 * p + 1 < N)
        begin : g_two
            assign pair_next[p] = ACC_W'(prod_reg[2*p]) + ACC_W'(prod_reg[2*p+1]);
        end
        else
        begin : g_one
            assign pair_next[p] = ACC_W'(prod_reg[2*p]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_add)
        begin
            pair_reg <= pair_next;
        end
    end

    // Final sum of the pairs (two at most)
    always_comb
    begin
        sum = '0;
        for (int p = 0; p < P; p++)
        begin
            sum = sum + pair_reg[p];
        end
    end

    // Floor shift, then clip when the bits above the result are not all sign
    assign shifted = sum >>> FRAC_BITS;
    assign upper   = shifted[ACC_W-1:DATA_W-1];
    assign sat     = !((&upper) || (~|upper));
    assign res     = sat ? (shifted[ACC_W-1] ? SAT_MIN : SAT_MAX)
                         : shifted[DATA_W-1:0];

endmodule

// ===== rtl/matrix4_column_transform_unit.sv =====
// ----------------------------------------------------------------------------
// matrix4_column_transform_unit
// Stored column-major matrix times a Q16.16 column vector, one row per lane.
//
//   channel | role   | handshake                     | word
//   cmd     | input  | cmd_valid / cmd_stall         | in_word_t: mode, column, vector
//   rsp     | output | rsp_valid / rsp_stall         | out_word_t: four rows, saturated
//
// Cycles: one word per cycle while cmd_stall is low; a transform taken passes the
//   multiply, pair-add and merge registers in turn, and the last raises rsp_valid.
// Load words write one matrix column at the edge they are taken and give no
//   result; a transform taken next cycle already sees the new column.
// Reset clears the pipeline valid flags only; the matrix is undefined until
//   loaded.
// cmd_stall rises only when all three stages hold words and rsp is stalled.
// ----------------------------------------------------------------------------
module matrix4_column_transform_unit #(
    parameter int DIM       = mct_pkg::DIM_DEF,
    parameter int FRAC_BITS = mct_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  mct_pkg::in_word_t  cmd_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output mct_pkg::out_word_t rsp_word
);
    import mct_pkg::*;

    // Only the first four rows and columns can ever be loaded
    localparam int N = (DIM < VEC_LEN) ? DIM : VEC_LEN;

    logic signed [DATA_W-1:0] mat_reg  [N][N];   // [column][row]
    logic signed [DATA_W-1:0] vec_all  [VEC_LEN];
    logic signed [DATA_W-1:0] vec_elem [N];
    logic signed [DATA_W-1:0] row_elem [N][N];   // [row][column]
    logic signed [DATA_W-1:0] lane_res [N];
    logic [N-1:0]             lane_sat;
    logic signed [DATA_W-1:0] res_all  [VEC_LEN];

    logic       v1_reg, v1_next;
    logic       v2_reg, v2_next;
    logic       rsp_valid_reg, rsp_valid_next;
    out_word_t  rsp_word_reg, rsp_word_next;
    logic       ready_out, ready2, ready1;
    logic       accept, xform_acc, load_acc;
    lane_ctrl_t ctrl;

    // Pipeline flow: a stage moves when the one after it is empty or moving
    assign ready_out = !rsp_valid_reg || !rsp_stall;
    assign ready2    = !v2_reg || ready_out;
    assign ready1    = !v1_reg || ready2;
    assign cmd_stall = !ready1;

    assign accept    = cmd_valid && ready1;
    assign xform_acc = accept && (cmd_word.mode == MODE_XFORM);
    assign load_acc  = accept && (cmd_word.mode == MODE_LOAD);

    assign ctrl.adv_mul = xform_acc;
    assign ctrl.adv_add = ready2 && v1_reg;

    always_comb
    begin
        v1_next        = ready1    ? xform_acc : v1_reg;
        v2_next        = ready2    ? v1_reg    : v2_reg;
        rsp_valid_next = ready_out ? v2_reg    : rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Vector elements of the incoming word
    assign vec_all[0] = cmd_word.vec_in0;
    assign vec_all[1] = cmd_word.vec_in1;
    assign vec_all[2] = cmd_word.vec_in2;
    assign vec_all[3] = cmd_word.vec_in3;

    // Matrix columns; a load to a column beyond the matrix is dropped
    for (genvar c = 0; c < N; c++)
    begin : g_col
        assign vec_elem[c] = vec_all[c];

        always_ff @(posedge clk)
        begin
            if (load_acc && (cmd_word.column_index == 2'(c)))
            begin
                for (int r = 0; r < N; r++)
                begin
                    mat_reg[c][r] <= vec_all[r];
                end
            end
        end
    end

    // One lane per matrix row
    for (genvar r = 0; r < N; r++)
    begin : g_lane
        for (genvar c = 0; c < N; c++)
        begin : g_tap
            assign row_elem[r][c] = mat_reg[c][r];
        end

        mct_lane #(
            .N         (N),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .ctrl     (ctrl),
            .row_elem (row_elem[r]),
            .vec_elem (vec_elem),
            .res      (lane_res[r]),
            .sat      (lane_sat[r])
        );
    end

    // Merge: rows beyond the matrix read zero, flag is any lane clipping
    always_comb
    begin
        for (int r = 0; r < VEC_LEN; r++)
        begin
            res_all[r] = '0;
        end
        for (int r = 0; r < N; r++)
        begin
            res_all[r] = lane_res[r];
        end
        rsp_word_next.res0      = res_all[0];
        rsp_word_next.res1      = res_all[1];
        rsp_word_next.res2      = res_all[2];
        rsp_word_next.res3      = res_all[3];
        rsp_word_next.saturated = |lane_sat;
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && v2_reg)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

// ===== rtl/mct_checker.sv =====
// ----------------------------------------------------------------------------
// mct_checker
// Port-level checks for the column transform unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mct_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input mct_pkg::in_word_t  cmd_word,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input mct_pkg::out_word_t rsp_word
);
    import mct_pkg::*;

    logic xform_taken;
    logic any_clip;

    assign xform_taken = cmd_valid && !cmd_stall && (cmd_word.mode == MODE_XFORM);

    // Some row sits at a range limit
    assign any_clip = (rsp_word.res0 == SAT_MAX) || (rsp_word.res0 == SAT_MIN) ||
                      (rsp_word.res1 == SAT_MAX) || (rsp_word.res1 == SAT_MIN) ||
                      (rsp_word.res2 == SAT_MAX) || (rsp_word.res2 == SAT_MIN) ||
                      (rsp_word.res3 == SAT_MAX) || (rsp_word.res3 == SAT_MIN);

    // No result word during reset
    `MCT_ASSERT_ALWAYS(a_no_rsp_in_reset, !rst_n |-> !rsp_valid, "rsp_valid high in reset")

    // Stalled result holds
    `MCT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "rsp word changed under stall")

    // Input stalls only when the output is full and stalled
    `MCT_ASSERT(a_stall_cause, cmd_stall |-> rsp_valid && rsp_stall, "cmd stalled without output backpressure")

    // A taken transform reaches the output when rsp is not stalled meanwhile
    `MCT_ASSERT(a_latency, xform_taken ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid, "transform word lost")

    // Saturation flag implies a clipped row
    `MCT_ASSERT(a_sat_clip, rsp_valid && rsp_word.saturated |-> any_clip, "saturated set without clipped row")

endmodule

bind matrix4_column_transform_unit mct_checker u_mct_checker (.*);

// ===== tb/sv/mct_result_checker.sv =====
// ----------------------------------------------------------------------------
// mct_result_checker
// Watches the cmd and rsp channels of the 4x4 column transform unit. It keeps
// its own copy of the matrix, works out the product word for every transform
// taken on cmd, and compares each rsp word with the oldest product waiting.
// ----------------------------------------------------------------------------
module mct_result_checker #(
    parameter int FRAC_BITS = mct_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_stall,
    input  mct_pkg::in_word_t  cmd_word,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  mct_pkg::out_word_t rsp_word,
    output int                 mismatches,
    output int                 pending
);
    import mct_pkg::*;

    // Shadow matrix, indexed [column][row]
    logic signed [DATA_W-1:0] matrix_cols [VEC_LEN][VEC_LEN];
    out_word_t                pending_products [$];
    out_word_t                want;

    // Matrix times vector: exact sums, floor shift, clip to 32 bits
    function automatic out_word_t transform_vector(input in_word_t w);
        logic signed [DATA_W-1:0] elem    [VEC_LEN];
        logic signed [DATA_W-1:0] row_val [VEC_LEN];
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  lhs;
        logic signed [ACC_W-1:0]  rhs;
        logic signed [ACC_W-1:0]  shifted;
        logic signed [ACC_W-1:0]  hi_lim;
        logic signed [ACC_W-1:0]  lo_lim;
        out_word_t                o;
        elem[0] = w.vec_in0;
        elem[1] = w.vec_in1;
        elem[2] = w.vec_in2;
        elem[3] = w.vec_in3;
        hi_lim = SAT_MAX;
        lo_lim = SAT_MIN;
        o = '0;
        for (int r = 0; r < VEC_LEN; r++)
        begin
            acc = '0;
            for (int c = 0; c < VEC_LEN; c++)
            begin
                lhs = matrix_cols[c][r];
                rhs = elem[c];
                acc = acc + lhs * rhs;
            end
            shifted = acc >>> FRAC_BITS;
            if (shifted > hi_lim)
            begin
                row_val[r] = SAT_MAX;
                o.saturated = 1'b1;
            end
            else if (shifted < lo_lim)
            begin
                row_val[r] = SAT_MIN;
                o.saturated = 1'b1;
            end
            else
            begin
                row_val[r] = shifted[DATA_W-1:0];
            end
        end
        o.res0 = row_val[0];
        o.res1 = row_val[1];
        o.res2 = row_val[2];
        o.res3 = row_val[3];
        return o;
    endfunction

    // Track taken words on both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_products.delete();
            pending = 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                if (cmd_word.mode == MODE_LOAD)
                begin
                    matrix_cols[cmd_word.column_index][0] = cmd_word.vec_in0;
                    matrix_cols[cmd_word.column_index][1] = cmd_word.vec_in1;
                    matrix_cols[cmd_word.column_index][2] = cmd_word.vec_in2;
                    matrix_cols[cmd_word.column_index][3] = cmd_word.vec_in3;
                end
                else
                begin
                    pending_products.push_back(transform_vector(cmd_word));
                end
            end

            if (rsp_valid && !rsp_stall)
            begin
                if (pending_products.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("rsp word with nothing pending: %h", rsp_word);
                end
                else
                begin
                    want = pending_products.pop_front();
                    if (want.res0 !== rsp_word.res0 || want.res1 !== rsp_word.res1 ||
                        want.res2 !== rsp_word.res2 || want.res3 !== rsp_word.res3 ||
                        want.saturated !== rsp_word.saturated)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: want %0d %0d %0d %0d sat %b",
                                     want.res0, want.res1, want.res2, want.res3,
                                     want.saturated);
                            $display("          got  %0d %0d %0d %0d sat %b",
                                     rsp_word.res0, rsp_word.res1, rsp_word.res2,
                                     rsp_word.res3, rsp_word.saturated);
                        end
                    end
                end
            end
            pending = pending_products.size();
        end
    end

endmodule

// ===== tb/sv/matrix4_column_transform_unit_tb.sv =====
// ----------------------------------------------------------------------------
// matrix4_column_transform_unit_tb
// Drives load and transform words into the column transform unit: a directed
// pass over identity, saturating and boundary matrices, then random streams
// under several idle/stall mixes, with one long rsp hold-off. The checker
// beside the block predicts and compares every rsp word.
// ----------------------------------------------------------------------------
module matrix4_column_transform_unit_tb;
    import mct_pkg::*;

    localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_TWO   = 32'sh0002_0000;
    localparam logic signed [DATA_W-1:0] Q_HALF_MAX = 32'sh4000_0000;
    localparam int                       RANDOM_WORDS = 1350;
    localparam int                       HOLD_CYCLES  = 60;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    in_word_t  cmd_word;
    logic      rsp_valid;
    logic      rsp_stall;
    out_word_t rsp_word;

    int fail_count;
    int pending_count;
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_go   = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    int idle_tbl  [4] = '{0, 61, 0, 13};
    int stall_tbl [4] = '{0, 0, 61, 13};

    matrix4_column_transform_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    mct_result_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_word   (cmd_word),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word),
        .mismatches (fail_count),
        .pending    (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // rsp side: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Offer one word on cmd after a random gap; returns at the negedge after it is taken
    task automatic send_word(input logic m, input logic [1:0] col,
                             input logic signed [DATA_W-1:0] e0,
                             input logic signed [DATA_W-1:0] e1,
                             input logic signed [DATA_W-1:0] e2,
                             input logic signed [DATA_W-1:0] e3);
        in_word_t w;
        w.mode         = m;
        w.column_index = col;
        w.vec_in0      = e0;
        w.vec_in1      = e1;
        w.vec_in2      = e2;
        w.vec_in3      = e3;
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        @(negedge clk);
    endtask

    // Element value: full range, small, extremes or mid-sized
    function automatic logic signed [DATA_W-1:0] pick_elem();
        logic signed [DATA_W-1:0] x;
        case ($urandom_range(4))
            0: x = $urandom;
            1, 4:
            begin
                x = $urandom_range(20'hF_FFFF);
                x = x - 32'sh0008_0000;
            end
            2:
            begin
                case ($urandom_range(3))
                    0: x = SAT_MAX;
                    1: x = SAT_MIN;
                    2: x = '0;
                    default: x = '1;
                endcase
            end
            default:
            begin
                x = $urandom;
                x = x >>> $urandom_range(24, 8);
            end
        endcase
        return x;
    endfunction

    task automatic send_random_word(input int xform_pct);
        send_word(($urandom_range(99) < xform_pct) ? MODE_XFORM : MODE_LOAD,
                  2'($urandom_range(3)), pick_elem(), pick_elem(), pick_elem(),
                  pick_elem());
    endtask

    initial
    begin
        // Reset edge after time zero so every reset process sees it
        rst_n     = 1'b1;
        cmd_valid = 1'b0;
        cmd_word  = '0;
        #1;
        rst_n     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Identity matrix: output equals input, point transform included
        for (int c = 0; c < VEC_LEN; c++)
            send_word(MODE_LOAD, 2'(c), (c == 0) ? Q_ONE : '0, (c == 1) ? Q_ONE : '0,
                      (c == 2) ? Q_ONE : '0, (c == 3) ? Q_ONE : '0);
        send_word(MODE_XFORM, 2'd3, Q_ONE, Q_TWO, -32'sh0003_0000, '0);
        send_word(MODE_XFORM, 2'd1, SAT_MAX, SAT_MIN, '1, 32'sd1);

        // All-max matrix: saturate high, low, and a cancelling mix
        for (int c = 0; c < VEC_LEN; c++)
            send_word(MODE_LOAD, 2'(c), SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
        send_word(MODE_XFORM, 2'd0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
        send_word(MODE_XFORM, 2'd2, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN);
        send_word(MODE_XFORM, 2'd3, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);

        // All-min matrix times min vector: largest exact sum
        for (int c = 0; c < VEC_LEN; c++)
            send_word(MODE_LOAD, 2'(c), SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
        send_word(MODE_XFORM, 2'd1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);

        // Diagonal 2.0: rows land just inside and just past both limits
        for (int c = 0; c < VEC_LEN; c++)
            send_word(MODE_LOAD, 2'(c), (c == 0) ? Q_TWO : '0, (c == 1) ? Q_TWO : '0,
                      (c == 2) ? Q_TWO : '0, (c == 3) ? Q_TWO : '0);
        send_word(MODE_XFORM, 2'd2, Q_HALF_MAX, Q_HALF_MAX - 1, -Q_HALF_MAX,
                  -Q_HALF_MAX - 1);

        // Random streams, one idle/stall mix per quarter
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_tbl[p];
            stall_pct = stall_tbl[p];
            if (p == 1)
            begin
                // Long rsp hold-off while cmd keeps offering transforms
                idle_pct = 0;
                hold_go  = 1'b1;
                repeat (24) send_random_word(100);
                idle_pct = idle_tbl[p];
            end
            repeat (RANDOM_WORDS / 4) send_random_word(80);
        end

        cmd_valid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
